// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by voxel_range_histogram_top.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted (active low)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

// plain invariant
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
    else $error("assertion failed: invariant");

`endif

// ----- design/vrh_pkg.sv -----
// ----------------------------------------------------------------------------
// vrh_pkg
// Shared types and constants of the voxel range histogram.
// ----------------------------------------------------------------------------
package vrh_pkg;

  localparam int BINS_W  = 9;   // width of the bins_in_use register
  localparam int QUOT_W  = 9;   // quotient bits of the bin divider
  localparam int IDX_W   = 8;   // bin_index / read_bin width
  localparam int OUT_W   = 32;  // bin_count width
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_RANGE_LOW   = 2'd0;
  localparam logic [1:0] REG_RANGE_HIGH  = 2'd1;
  localparam logic [1:0] REG_BINS_IN_USE = 2'd2;

  localparam logic [15:0] RANGE_LOW_RST   = 16'd0;
  localparam logic [15:0] RANGE_HIGH_RST  = 16'd65535;
  localparam logic [BINS_W-1:0] BINS_RST  = 9'd256;

  // controller -> datapath
  typedef struct packed {
    logic in_take;   // latch the accepted item
    logic mul;       // form product and special-case flags
    logic div_step;  // one restoring division step
    logic rd;        // read the count store
    logic wb;        // write back, and load the output register on a read
    logic clr_step;  // clear one entry of the count store
  } vrh_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_read;   // latched item is a read-and-clear
    logic out_free;  // output register can take a result this cycle
    logic clr_last;  // clearing pass is at its last entry
  } vrh_status_t;

endpackage

// ----- design/vrh_cfg.sv -----
// ----------------------------------------------------------------------------
// vrh_cfg
// APB register file: range bounds and number of bins in use.
// ----------------------------------------------------------------------------
module vrh_cfg #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vrh_pkg::PADDR_W-1:0] paddr,
  input  logic [vrh_pkg::PDATA_W-1:0] pwdata,
  output logic [vrh_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output logic [SAMPLE_BITS-1:0]      range_low,
  output logic [SAMPLE_BITS-1:0]      range_high,
  output logic [vrh_pkg::BINS_W-1:0]  bins_in_use
);
  import vrh_pkg::*;

  logic [SAMPLE_BITS-1:0] range_low_r;
  logic [SAMPLE_BITS-1:0] range_high_r;
  logic [BINS_W-1:0]      bins_r;
  logic [1:0]             reg_idx;
  logic                   wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= SAMPLE_BITS'(RANGE_LOW_RST);
      range_high_r <= SAMPLE_BITS'(RANGE_HIGH_RST);
      bins_r       <= BINS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_RANGE_LOW:   range_low_r  <= pwdata[SAMPLE_BITS-1:0];
        REG_RANGE_HIGH:  range_high_r <= pwdata[SAMPLE_BITS-1:0];
        REG_BINS_IN_USE: bins_r       <= pwdata[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RANGE_LOW:   prdata = PDATA_W'(range_low_r);
      REG_RANGE_HIGH:  prdata = PDATA_W'(range_high_r);
      REG_BINS_IN_USE: prdata = PDATA_W'(bins_r);
      default:         prdata = '0;
    endcase
  end

  assign range_low   = range_low_r;
  assign range_high  = range_high_r;
  assign bins_in_use = bins_r;

endmodule

// ----- design/vrh_dp.sv -----
// ----------------------------------------------------------------------------
// vrh_dp
// Datapath: bin arithmetic, serial divider, count store and output register.
// ----------------------------------------------------------------------------
module vrh_dp #(
  parameter int MAX_BINS    = 256,
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  vrh_pkg::vrh_cmd_t           cmd,
  output vrh_pkg::vrh_status_t        status,
  input  logic                        in_mode,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic [vrh_pkg::IDX_W-1:0]   in_bin_index,
  input  logic [SAMPLE_BITS-1:0]      range_low,
  input  logic [SAMPLE_BITS-1:0]      range_high,
  input  logic [vrh_pkg::BINS_W-1:0]  bins_in_use,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [vrh_pkg::IDX_W-1:0]   out_read_bin,
  output logic [vrh_pkg::OUT_W-1:0]   out_bin_count
);
  import vrh_pkg::*;

  localparam int AW = $clog2(MAX_BINS);
  localparam int NW = SAMPLE_BITS + QUOT_W;

  // latched item
  logic                   mode_r;
  logic [SAMPLE_BITS-1:0] sample_r;
  logic [IDX_W-1:0]       idx_r;

  // bin arithmetic
  logic [BINS_W-1:0]      bins_eff;
  logic [BINS_W-1:0]      bins_m1;
  logic [SAMPLE_BITS-1:0] diff;
  logic [SAMPLE_BITS-1:0] span;
  logic                   to_first;
  logic                   to_last;
  logic [NW-1:0]          rem_r;
  logic [NW-1:0]          div_r;
  logic [QUOT_W-1:0]      q_r;
  logic                   spec_r;
  logic [QUOT_W-1:0]      spec_bin_r;
  logic                   ge;
  logic [QUOT_W-1:0]      bin;

  // count store
  logic [COUNT_BITS-1:0]  mem [MAX_BINS];
  logic [COUNT_BITS-1:0]  rd_data_r;
  logic [COUNT_BITS-1:0]  sat_inc;
  logic [AW-1:0]          clr_r;
  logic [AW+QUOT_W-1:0]   bin_ext;
  logic [AW+IDX_W-1:0]    idx_ext;
  logic [AW-1:0]          mem_addr;
  logic                   idx_ok;
  logic                   mem_we;
  logic [AW-1:0]          mem_wa;
  logic [COUNT_BITS-1:0]  mem_wd;
  logic [COUNT_BITS+OUT_W-1:0] cnt_ext;

  // output register
  logic                   out_valid_r;
  logic [IDX_W-1:0]       out_bin_r;
  logic [OUT_W-1:0]       out_cnt_r;

  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      mode_r   <= in_mode;
      sample_r <= in_sample;
      idx_r    <= in_bin_index;
    end
  end

  // bins_in_use above the store depth acts as the depth
  assign bins_eff = (32'(bins_in_use) > 32'(MAX_BINS)) ? BINS_W'(MAX_BINS) : bins_in_use;
  assign bins_m1  = bins_eff - BINS_W'(1);
  assign diff     = sample_r - range_low;
  assign span     = range_high - range_low;
  assign to_first = (bins_eff < BINS_W'(2)) || (range_high <= range_low) ||
                    (sample_r <= range_low);
  assign to_last  = !to_first && (sample_r >= range_high);
  assign ge       = (rem_r >= div_r);

  // quotient is known to stay below 2^QUOT_W, so the divisor starts shifted
  // up by QUOT_W-1 and moves down one place a step
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r      <= NW'(diff) * NW'(bins_m1);
      div_r      <= NW'(span) << (QUOT_W - 1);
      spec_r     <= to_first || to_last;
      spec_bin_r <= to_last ? QUOT_W'(bins_m1) : '0;
    end else if (cmd.div_step) begin
      if (ge) begin
        rem_r <= rem_r - div_r;
      end
      div_r <= div_r >> 1;
      q_r   <= {q_r[QUOT_W-2:0], ge};
    end
  end

  assign bin      = spec_r ? spec_bin_r : q_r;
  assign bin_ext  = {{AW{1'b0}}, bin};
  assign idx_ext  = {{AW{1'b0}}, idx_r};
  assign mem_addr = mode_r ? idx_ext[AW-1:0] : bin_ext[AW-1:0];
  assign idx_ok   = (32'(idx_r) < 32'(MAX_BINS));
  assign sat_inc  = (&rd_data_r) ? rd_data_r : rd_data_r + COUNT_BITS'(1);
  assign cnt_ext  = {{OUT_W{1'b0}}, rd_data_r};

  assign mem_we = cmd.clr_step || (cmd.wb && (!mode_r || idx_ok));
  assign mem_wa = cmd.clr_step ? clr_r : mem_addr;
  assign mem_wd = (cmd.clr_step || mode_r) ? '0 : sat_inc;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[mem_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_r <= clr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.wb && mode_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb && mode_r) begin
      out_bin_r <= idx_r;
      out_cnt_r <= idx_ok ? cnt_ext[OUT_W-1:0] : '0;
    end
  end

  assign status.is_read  = mode_r;
  assign status.out_free = !out_valid_r || !out_stall;
  assign status.clr_last = (clr_r == AW'(MAX_BINS - 1));

  assign out_valid     = out_valid_r;
  assign out_read_bin  = out_bin_r;
  assign out_bin_count = out_cnt_r;

endmodule

// ----- design/vrh_ctrl.sv -----
// ----------------------------------------------------------------------------
// vrh_ctrl
// Controller: clearing pass, item sequencing and divider step count.
// ----------------------------------------------------------------------------
module vrh_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_mode,
  output logic                 in_stall,
  output vrh_pkg::vrh_cmd_t    cmd,
  input  vrh_pkg::vrh_status_t status
);
  import vrh_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_RD    = 3'd4;
  localparam logic [2:0] ST_WB    = 3'd5;

  localparam int CNT_W = $clog2(QUOT_W);

  logic [2:0]       state_r;
  logic [2:0]       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_take = 1'b1;
          state_nxt   = in_mode ? ST_RD : ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(QUOT_W - 1)) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        // a read waits here until the output register has room
        if (!status.is_read || status.out_free) begin
          cmd.wb    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- design/voxel_range_histogram_top.sv -----
// ----------------------------------------------------------------------------
// voxel_range_histogram_top
// Histogram of voxel samples over a configured value range.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): in_mode 0 bins in_sample and adds one
// to that bin's saturating count; in_mode 1 returns the count of bin
// in_bin_index on the output channel and clears the bin.
// Output channel (out_valid / out_stall): one transfer per read item, held
// in an output register until taken.
// APB port: range_low at 0x0, range_high at 0x4, bins_in_use at 0x8.
// Write it only while no item is in flight.
// Sequencing: an accumulate item passes through a multiply, a 9-step
// restoring divider, then a read-modify-write of the count store. A read
// item passes through a read of the count store and a write-back that loads
// the output register. Items are handled one at a time.
// Reset: the count store is swept to zero, one entry per cycle, across all
// MAX_BINS entries; in_stall is high throughout.
// A stalled result does not block accumulate items; a second read item waits
// in write-back, holding in_stall high, until the output register empties.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_range_histogram_top #(
  parameter int MAX_BINS    = 256,
  parameter int COUNT_BITS  = 32,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_mode,
  input  logic [SAMPLE_BITS-1:0]      in_sample,
  input  logic [vrh_pkg::IDX_W-1:0]   in_bin_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [vrh_pkg::IDX_W-1:0]   out_read_bin,
  output logic [vrh_pkg::OUT_W-1:0]   out_bin_count,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vrh_pkg::PADDR_W-1:0] paddr,
  input  logic [vrh_pkg::PDATA_W-1:0] pwdata,
  output logic [vrh_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import vrh_pkg::*;

  logic [SAMPLE_BITS-1:0] range_low;
  logic [SAMPLE_BITS-1:0] range_high;
  logic [BINS_W-1:0]      bins_in_use;
  vrh_cmd_t               cmd;
  vrh_status_t            status;
  logic                   in_xfer;

  vrh_cfg #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .range_low   (range_low),
    .range_high  (range_high),
    .bins_in_use (bins_in_use)
  );

  vrh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_mode  (in_mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  vrh_dp #(
    .MAX_BINS    (MAX_BINS),
    .COUNT_BITS  (COUNT_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .in_mode       (in_mode),
    .in_sample     (in_sample),
    .in_bin_index  (in_bin_index),
    .range_low     (range_low),
    .range_high    (range_high),
    .bins_in_use   (bins_in_use),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_read_bin  (out_read_bin),
    .out_bin_count (out_bin_count)
  );

  assign in_xfer = in_valid && !in_stall;

  // one item at a time: after a transfer the block is busy
  `ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_xfer, in_stall)
  // a read result is never loaded over one that is still waiting
  `ASSERT_IMPLIES(a_no_result_overwrite, clk, rst_n, cmd.wb && status.is_read, status.out_free)
  // controller issues at most one command per cycle
  `ASSERT_ALWAYS(a_cmd_onehot, clk, rst_n, $onehot0(cmd))

endmodule
